>>> rtl/core/spq_pkg.sv
`timescale 1ns / 1ps

package spq_pkg;

	// Default number of entry cells in the queue.
	localparam int CAPACITY_DEF = 16;

	// Field widths fixed by the interface.
	localparam int ID_W   = 16;
	localparam int PRIO_W = 8;
	localparam int OCC_W  = 5;

	// Item kinds on the request channel.
	localparam logic KIND_INSERT = 1'b0;
	localparam logic KIND_REMOVE = 1'b1;

	// Result codes on the response channel.
	typedef enum logic [1:0] {
		ST_INSERTED = 2'd0,
		ST_REMOVED  = 2'd1,
		ST_EMPTY    = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	// One request beat.
	typedef struct packed {
		logic              kind;
		logic [ID_W-1:0]   req_id;
		logic [PRIO_W-1:0] req_priority;
	} req_t;

	// One response beat.
	typedef struct packed {
		status_t           status;
		logic [ID_W-1:0]   out_id;
		logic [PRIO_W-1:0] out_priority;
		logic [OCC_W-1:0]  occupancy;
	} rsp_t;

	// Contents of one queue slot.
	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [PRIO_W-1:0] prio;
	} entry_t;

	// Commands broadcast from the control logic to every cell.
	typedef struct packed {
		logic   insert;
		logic   remove;
		entry_t entry;
	} cell_ctrl_t;

endpackage

>>> rtl/core/spq_cell.sv
`timescale 1ns / 1ps

// One slot of the sorted chain. On an insert the slot keeps its entry if it
// sorts at or ahead of the new one, takes the new entry if it is the first
// slot behind, and otherwise takes its upstream neighbor's entry. On a
// remove every slot takes its downstream neighbor's entry.
module spq_cell (
	input  logic                clk,
	input  spq_pkg::cell_ctrl_t ctrl,
	input  logic                occupied,
	input  logic                prev_le,
	input  spq_pkg::entry_t     prev_data,
	input  spq_pkg::entry_t     next_data,
	output spq_pkg::entry_t     data,
	output logic                le
);

	spq_pkg::entry_t data_q;

	// An occupied slot whose priority is not above the new one stays ahead of it.
	assign le   = occupied && (data_q.prio <= ctrl.entry.prio);
	assign data = data_q;

	// Slot update.
	always_ff @(posedge clk) begin
		if (ctrl.insert) begin
			if (!le) begin
				data_q <= prev_le ? ctrl.entry : prev_data;
			end
		end else if (ctrl.remove) begin
			data_q <= next_data;
		end
	end

endmodule

>>> rtl/core/stable_priority_request_queue.sv
`timescale 1ns / 1ps
// Response: the response beat for a request is registered and appears in the cycle after the request beat is taken.
// Throughput: one request per cycle unless rsp_ready stalls the response register; every cell
// compares with the new entry in parallel and the slots shift in the same cycle, so no operation iterates.
// Reset: arst_n clears the entry count and the response valid; slot contents are not cleared
// and are never read before they are written.
module stable_priority_request_queue #(
	parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  spq_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output spq_pkg::rsp_t rsp
);

	localparam int CW = $clog2(CAPACITY + 1);

	logic                accept;
	logic                empty;
	logic                full;
	logic [CW-1:0]       count_q;
	logic [CW-1:0]       count_next;
	spq_pkg::cell_ctrl_t ctrl;
	spq_pkg::rsp_t       rsp_d;
	spq_pkg::rsp_t       rsp_q;
	logic                rsp_valid_q;

	spq_pkg::entry_t cell_data [CAPACITY];
	logic            cell_le   [CAPACITY];

	// A new request is taken whenever the response register is free or draining.
	assign req_ready = !rsp_valid_q || rsp_ready;
	assign accept    = req_valid && req_ready;
	assign empty     = (count_q == '0);
	assign full      = (count_q == CW'(CAPACITY));

	// Commands to the chain.
	always_comb begin
		ctrl.insert     = accept && (req.kind == spq_pkg::KIND_INSERT) && !full;
		ctrl.remove     = accept && (req.kind == spq_pkg::KIND_REMOVE) && !empty;
		ctrl.entry.id   = req.req_id;
		ctrl.entry.prio = req.req_priority;
	end

	// Occupancy after this beat.
	always_comb begin
		count_next = count_q;
		if (ctrl.insert) begin
			count_next = count_q + CW'(1);
		end else if (ctrl.remove) begin
			count_next = count_q - CW'(1);
		end
	end

	// The chain of slots; slot 0 is the head.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic            occupied;
		logic            prev_le;
		spq_pkg::entry_t prev_data;
		spq_pkg::entry_t next_data;

		assign occupied = (count_q > CW'(i));

		if (i == 0) begin : g_first
			assign prev_le   = 1'b1;
			assign prev_data = cell_data[i];
		end else begin : g_mid
			assign prev_le   = cell_le[i-1];
			assign prev_data = cell_data[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign next_data = cell_data[i];
		end else begin : g_inner
			assign next_data = cell_data[i+1];
		end

		spq_cell u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.occupied  (occupied),
			.prev_le   (prev_le),
			.prev_data (prev_data),
			.next_data (next_data),
			.data      (cell_data[i]),
			.le        (cell_le[i])
		);
	end

	// Response for the current request.
	always_comb begin
		rsp_d.status       = spq_pkg::ST_INSERTED;
		rsp_d.out_id       = '0;
		rsp_d.out_priority = '0;
		rsp_d.occupancy    = spq_pkg::OCC_W'(count_next);
		if (req.kind == spq_pkg::KIND_REMOVE) begin
			if (empty) begin
				rsp_d.status = spq_pkg::ST_EMPTY;
			end else begin
				rsp_d.status       = spq_pkg::ST_REMOVED;
				rsp_d.out_id       = cell_data[0].id;
				rsp_d.out_priority = cell_data[0].prio;
			end
		end else if (full) begin
			rsp_d.status = spq_pkg::ST_FULL;
		end
	end

	// Entry count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_next;
		end
	end

	// Response register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (req_ready) begin
			rsp_valid_q <= req_valid;
		end
	end

	// Response register payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// The count never passes the number of slots.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	// The two leading slots are held in priority order.
	a_head_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q >= CW'(2)) |-> (cell_data[0].prio <= cell_data[1].prio))
		else $error("head slots out of order");

	// A remove from a non-empty queue drops the count by one.
	a_remove_count: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req.kind == spq_pkg::KIND_REMOVE && !empty)
		|=> (count_q == $past(count_q) - CW'(1)))
		else $error("remove did not lower the count");

	// An insert into a full queue is reported as dropped.
	a_full_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req.kind == spq_pkg::KIND_INSERT && full)
		|=> (rsp_valid && rsp.status == spq_pkg::ST_FULL && count_q == $past(count_q)))
		else $error("insert into full queue not dropped");

endmodule
